// ===== rtl/pidq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the process id queue.
// Depends on nothing; used by process_id_queue.
package pidq_pkg;

    // Default sizes handed to the top level.
    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_ID_WIDTH    = 16;

    // Fixed widths of the stream fields.
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_ID_W     = 16;
    localparam int OUT_ID_W    = 16;
    localparam int COUNT_OUT_W = 5;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    // Commands carried on the slave-side tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_FIND    = 2'd2,
        CMD_EXTRACT = 2'd3
    } cmd_t;

    // Result status carried on the master-side tuser.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

// ===== rtl/pidq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
module pidq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/process_id_queue.sv =====
`timescale 1ns / 1ps
// Process id queue: push, pop front, find and ordered extract over a circular RAM.
// Depends on pidq_pkg and pidq_ram.
// A push is written in the idle state; a pop takes the head entry in S_POP_RD; find
// and extract scan entries from the head in S_SCAN, and an extract then shifts the
// entries behind the match one place toward the head in S_SHIFT. Scan and shift
// together visit at most count entries, one per cycle; every result passes S_DONE.
// A new word is taken only in the idle state; a finished result waits in the output
// register. Synchronous active-low reset empties the queue; RAM contents are kept.
module process_id_queue #(
    parameter int QUEUE_DEPTH = pidq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_WIDTH    = pidq_pkg::DEFAULT_ID_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Slave side.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pidq_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [15:0] item_id
    input  logic [pidq_pkg::CMD_W-1:0]       s_axis_tuser,  // [1:0] command
    // Master side.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pidq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [15:0] result_id,
                                                            // [20:16] entry_count
    output logic [pidq_pkg::STATUS_W-1:0]    m_axis_tuser   // [1:0] status
);

    import pidq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PAD_W = OUT_DATA_W - OUT_ID_W - COUNT_OUT_W;
    localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_P  = IDX_W'(QUEUE_DEPTH - 1);

    // Physical RAM address of a logical position counted from the head.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] lidx);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [ID_WIDTH-1:0]  id_reg, id_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     wr_idx_reg, wr_idx_next;
    status_t              res_status_reg, res_status_next;
    logic [ID_WIDTH-1:0]  res_id_reg, res_id_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [OUT_ID_W-1:0]  m_id_reg, m_id_next;
    logic [COUNT_OUT_W-1:0] m_count_reg, m_count_next;

    logic                 ram_we, ram_re;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [ID_WIDTH-1:0]  ram_wdata, ram_rdata;

    logic                 s_accept;
    cmd_t                 cmd_in;
    logic [ID_WIDTH-1:0]  id_in;
    logic                 full, empty, at_last, match, out_free;
    logic [CNT_W-1:0]     last_idx;

    pidq_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and status decode.
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cmd_in        = cmd_t'(s_axis_tuser);
    assign id_in         = ID_WIDTH'(s_axis_tdata[IN_ID_W-1:0]);
    assign full          = (count_reg == DEPTH_C);
    assign empty         = (count_reg == '0);
    assign last_idx      = count_reg - CNT_W'(1);
    assign at_last       = (CNT_W'(rd_idx_reg) == last_idx);
    assign match         = (ram_rdata == id_reg);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (cmd_in)
                        CMD_PUSH:    state_next = S_DONE;
                        CMD_POP:     state_next = empty ? S_DONE : S_POP_RD;
                        CMD_FIND:    state_next = empty ? S_DONE : S_SCAN;
                        CMD_EXTRACT: state_next = empty ? S_DONE : S_SCAN;
                    endcase
                end
            end
            S_POP_RD: state_next = S_DONE;
            S_SCAN: begin
                if (match) begin
                    state_next = (cmd_reg == CMD_EXTRACT && !at_last) ? S_SHIFT : S_DONE;
                end else begin
                    state_next = at_last ? S_DONE : S_SCAN;
                end
            end
            S_SHIFT: state_next = at_last ? S_DONE : S_SHIFT;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM control and output register loading.
    always_comb begin
        head_next       = head_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_count_next    = m_count_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = phys(head_reg, wr_idx_reg);
        ram_wdata       = ram_rdata;
        ram_raddr       = phys(head_reg, rd_idx_reg + IDX_W'(1));
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cmd_next        = cmd_in;
                    id_next         = id_in;
                    rd_idx_next     = '0;
                    res_status_next = STATUS_MISS;
                    res_id_next     = '0;
                    unique case (cmd_in)
                        CMD_PUSH: begin
                            if (full) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                ram_we          = 1'b1;
                                ram_waddr       = phys(head_reg, count_reg[IDX_W-1:0]);
                                ram_wdata       = id_in;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = STATUS_OK;
                                res_id_next     = id_in;
                            end
                        end
                        CMD_POP, CMD_FIND, CMD_EXTRACT: begin
                            ram_re    = !empty;
                            ram_raddr = head_reg;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                res_status_next = STATUS_OK;
                res_id_next     = ram_rdata;
                head_next       = (head_reg == LAST_P) ? '0 : head_reg + IDX_W'(1);
                count_next      = count_reg - CNT_W'(1);
            end
            S_SCAN: begin
                if (match) begin
                    res_status_next = STATUS_OK;
                    res_id_next     = ram_rdata;
                    if (cmd_reg == CMD_EXTRACT) begin
                        if (at_last) begin
                            count_next = count_reg - CNT_W'(1);
                        end else begin
                            wr_idx_next = rd_idx_reg;
                            ram_re      = 1'b1;
                            rd_idx_next = rd_idx_reg + IDX_W'(1);
                        end
                    end
                end else if (!at_last) begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            S_SHIFT: begin
                // Move the entry behind the gap one place toward the head.
                ram_we = 1'b1;
                if (at_last) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                    wr_idx_next = wr_idx_reg + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_id_next     = OUT_ID_W'(res_id_reg);
                    m_count_next  = COUNT_OUT_W'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        m_status_reg   <= m_status_next;
        m_id_reg       <= m_id_next;
        m_count_reg    <= m_count_next;
    end

    // Output word.
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_count_reg, m_id_reg};
    assign m_axis_tuser  = m_status_reg;

    // The fill level never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count exceeds depth");

    // An accepted push into a non-full queue raises the count by one.
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && cmd_in == CMD_PUSH && !full) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not raise the count");

    // During a shift the write and read never target the same entry.
    a_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> ram_waddr != ram_raddr)
        else $error("RAM write and read collide");

    // The scan stays inside the occupied part of the queue.
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_SHIFT) |-> CNT_W'(rd_idx_reg) < count_reg)
        else $error("scan index beyond queue count");

    // A result that is not successful carries a zero id.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_status_reg == STATUS_OK || m_id_reg == '0))
        else $error("failed result with non-zero id");

endmodule
